[hdl/tlc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tlc_pkg;
  localparam int L1_SETS   = 512;
  localparam int L1_WAYS   = 4;
  localparam int L2_SETS   = 2048;
  localparam int L2_WAYS   = 8;
  localparam int ADDR_BITS = 23;

  localparam int L1_IDX_W = $clog2(L1_SETS);
  localparam int L2_IDX_W = $clog2(L2_SETS);
  localparam int L1_POS_W = $clog2(L1_WAYS + 1);
  localparam int L2_POS_W = $clog2(L2_WAYS + 1);

  localparam logic [1:0] HIT_L1   = 2'd0;
  localparam logic [1:0] HIT_L2   = 2'd1;
  localparam logic [1:0] HIT_MISS = 2'd2;

  typedef struct packed {
    logic                 valid;
    logic                 dirty;
    logic [ADDR_BITS-1:0] tag;
  } entry_t;

  typedef entry_t [L1_WAYS-1:0] l1_set_t;
  typedef entry_t [L2_WAYS-1:0] l2_set_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic read;
    logic update;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
  } status_t;
endpackage
`default_nettype wire

[hdl/tlc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module tlc_ctrl
  import tlc_pkg::*;
(
  input  wire     clk,
  input  wire     rst_n,
  input  wire     in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  wire     out_stall,
  input  status_t status,
  output cmd_t    cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_stall) |=> state_r == ST_OUT)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.read)
    else $error("read did not follow capture");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> out_valid)
    else $error("result missing after write");
endmodule
`default_nettype wire

[hdl/tlc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module tlc_datapath
  import tlc_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  cmd_t                 cmd,
  output status_t              status,
  input  wire [ADDR_BITS-1:0]  in_line_address,
  input  wire                  in_line_dirty,
  output logic [1:0]           out_hit_level,
  output logic                 out_writeback_valid,
  output logic [ADDR_BITS-1:0] out_writeback_address
);
  l1_set_t l1_mem [L1_SETS];
  l2_set_t l2_mem [L2_SETS];

  logic [ADDR_BITS-1:0] addr_r;
  logic                 dirty_r;
  l1_set_t              s1_r, s1_nxt;
  l2_set_t              s2_r, s2_nxt;
  logic [1:0]           hit_r, hit_nxt;
  logic                 wb_v_r, wb_v_nxt;
  logic [ADDR_BITS-1:0] wb_a_r, wb_a_nxt;
  logic [L2_IDX_W-1:0]  clr_r;
  logic                 clr_done_r;

  logic [L1_IDX_W-1:0] i1;
  logic [L2_IDX_W-1:0] i2;
  assign i1 = cmd.clear_step ? clr_r[L1_IDX_W-1:0] : addr_r[L1_IDX_W-1:0];
  assign i2 = cmd.clear_step ? clr_r : addr_r[L2_IDX_W-1:0];

  // Sweep both set memories once after reset; L2 is the deeper of the two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clear_step) begin
      clr_r      <= clr_r + 1'b1;
      clr_done_r <= (clr_r == L2_IDX_W'(L2_SETS - 1));
    end
  end
  assign status.clear_done = clr_done_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r  <= in_line_address;
      dirty_r <= in_line_dirty;
    end
    if (cmd.read) begin
      s1_r <= l1_mem[i1];
      s2_r <= l2_mem[i2];
    end
    if (cmd.update) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      hit_r  <= hit_nxt;
      wb_v_r <= wb_v_nxt;
      wb_a_r <= wb_a_nxt;
    end
    if (cmd.clear_step || cmd.write) begin
      l1_mem[i1] <= cmd.clear_step ? l1_set_t'('0) : s1_r;
      l2_mem[i2] <= cmd.clear_step ? l2_set_t'('0) : s2_r;
    end
  end

  // Lowest matching way in each set.
  logic [L1_POS_W-1:0] p1;
  logic [L2_POS_W-1:0] p2;
  always_comb begin
    p1 = L1_POS_W'(L1_WAYS);
    for (int i = L1_WAYS - 1; i >= 0; i--) begin
      if (s1_r[i].valid && s1_r[i].tag == addr_r) p1 = L1_POS_W'(i);
    end
    p2 = L2_POS_W'(L2_WAYS);
    for (int i = L2_WAYS - 1; i >= 0; i--) begin
      if (s2_r[i].valid && s2_r[i].tag == addr_r) p2 = L2_POS_W'(i);
    end
  end

  entry_t l1_front, l2_front;
  always_comb begin
    s1_nxt   = s1_r;
    s2_nxt   = s2_r;
    hit_nxt  = HIT_MISS;
    wb_v_nxt = 1'b0;
    wb_a_nxt = '0;
    l1_front = '0;
    l2_front = '0;
    if (p1 != L1_POS_W'(L1_WAYS)) begin
      hit_nxt   = HIT_L1;
      s1_nxt[0] = s1_r[p1[L1_POS_W-2:0]];
      for (int i = 1; i < L1_WAYS; i++) begin
        if (L1_POS_W'(i) <= p1) s1_nxt[i] = s1_r[i-1];
      end
    end else begin
      if (p2 != L2_POS_W'(L2_WAYS)) begin
        hit_nxt  = HIT_L2;
        l1_front = s2_r[p2[L2_POS_W-2:0]];
        l2_front = s1_r[L1_WAYS-1];
        for (int i = 1; i < L2_WAYS; i++) begin
          if (L2_POS_W'(i) <= p2) s2_nxt[i] = s2_r[i-1];
        end
      end else begin
        l1_front = '{valid: 1'b1, dirty: dirty_r, tag: addr_r};
        l2_front = s1_r[L1_WAYS-1];
        for (int i = 1; i < L2_WAYS; i++) s2_nxt[i] = s2_r[i-1];
        wb_v_nxt = s2_r[L2_WAYS-1].valid && s2_r[L2_WAYS-1].dirty;
        wb_a_nxt = wb_v_nxt ? s2_r[L2_WAYS-1].tag : '0;
      end
      s2_nxt[0] = l2_front;
      s1_nxt[0] = l1_front;
      for (int i = 1; i < L1_WAYS; i++) s1_nxt[i] = s1_r[i-1];
    end
  end

  assign out_hit_level         = hit_r;
  assign out_writeback_valid   = wb_v_r;
  assign out_writeback_address = wb_a_r;
endmodule
`default_nettype wire

[hdl/two_level_lru_cache_tags.sv]
`timescale 1ns / 1ps
`default_nettype none
// An accepted input word is captured, then passes through the read, update and
// write states before its result word is presented; the result holds while
// out_stall is high. No new word is taken until that result is taken. Each access
// does one read-modify-write of the L1 and L2 set memories.
// Reset: after rst_n a clearing pass over all L2_SETS indices invalidates
// both set memories; no input word is taken until it finishes.
module two_level_lru_cache_tags
  import tlc_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire [ADDR_BITS-1:0]  in_line_address,
  input  wire                  in_line_dirty,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [1:0]           out_hit_level,
  output logic                 out_writeback_valid,
  output logic [ADDR_BITS-1:0] out_writeback_address
);
  cmd_t    cmd;
  status_t status;

  // Sequencer: clear sweep, then capture, read, update, write, present.
  tlc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .status, .cmd
  );

  // Set memories and the recency reorder logic.
  tlc_datapath u_dp (
    .clk, .rst_n, .cmd, .status, .in_line_address, .in_line_dirty,
    .out_hit_level, .out_writeback_valid, .out_writeback_address
  );
endmodule
`default_nettype wire
